[hw/rtl/oabs_pkg.sv]
package oabs_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned DIM_W   = 13;
   localparam int unsigned PIX_W   = 32;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned IDX_W   = 3;

   // Signed width that holds a coordinate plus or minus a dimension difference.
   localparam int unsigned POS_W   = DIM_W + 2;

   localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'hFF;

   localparam logic [IDX_W-1:0] CSR_DEST_WIDTH     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_DEST_HEIGHT    = 3'd1;
   localparam logic [IDX_W-1:0] CSR_OVERLAY_WIDTH  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_OVERLAY_HEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] CSR_SNAP_CORNER    = 3'd4;

   localparam logic [1:0] SNAP_TOP_LEFT     = 2'd0;
   localparam logic [1:0] SNAP_TOP_RIGHT    = 2'd1;
   localparam logic [1:0] SNAP_BOTTOM_LEFT  = 2'd2;
   localparam logic [1:0] SNAP_BOTTOM_RIGHT = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] overlay_col;
      logic [COORD_W-1:0] overlay_row;
      logic [PIX_W-1:0]   overlay_pixel;
      logic [PIX_W-1:0]   dest_pixel;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [PIX_W-1:0]   out_pixel;
      logic               write_ok;
   } rsp_type;

   // Exact floor(n / 255) for any n up to 65279: add the high byte and one, drop a byte.
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

[hw/rtl/oabs_mix.sv]
module oabs_mix (
   input  logic                        clock,
   input  logic [oabs_pkg::CHAN_W-1:0] src,
   input  logic [oabs_pkg::CHAN_W-1:0] dst,
   input  logic [oabs_pkg::CHAN_W-1:0] alpha,
   output logic [oabs_pkg::CHAN_W-1:0] mixed
);
   import oabs_pkg::*;

   logic [15:0] prod_src_ff;
   logic [15:0] prod_dst_ff;
   logic [15:0] sum_ff;
   logic [15:0] sum_in;

   // The weight of the destination is 255 - alpha, formed at eight bits before widening.
   always_ff @(posedge clock) begin
      prod_src_ff <= {8'd0, src} * {8'd0, alpha};
      prod_dst_ff <= {8'd0, dst} * {8'd0, FULL_ALPHA - alpha};
      sum_ff      <= sum_in;
   end

   // Sum stays at or below 255 * 255, so 16 bits never overflow.
   assign sum_in = prod_src_ff + prod_dst_ff;
   assign mixed  = div255(sum_ff);

endmodule

[hw/rtl/overlay_alpha_blend_snap.sv]
// Channel  Ports                             Beat moves on
// -------  --------------------------------  ------------------------------
// input    start, busy, req_data             start high and busy low
// result   rsp_valid, rsp_data               rsp_valid high, one cycle only
// config   csr_we, csr_index, csr_data       csr_we high
//
// One beat is accepted every cycle; busy is never raised.
// Results appear in the same order as their input beats.
// The depth is set by multiply, add, then divide-by-255 register stages.
// Reset clears the valid pipeline, restores all dimensions to one and snaps to top-left.
// The result side cannot stall, so nothing in the pipeline ever waits.
module overlay_alpha_blend_snap #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  oabs_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output oabs_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [oabs_pkg::IDX_W-1:0]   csr_index,
   input  logic [oabs_pkg::DIM_W-1:0]   csr_data
);
   import oabs_pkg::*;

   localparam int unsigned DimCapInt = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
   localparam logic [DIM_W-1:0] DimCap = DIM_W'(DimCapInt);

   logic [DIM_W-1:0] dest_w_ff, dest_h_ff, ovl_w_ff, ovl_h_ff;
   logic [1:0]       snap_ff;
   logic [DIM_W-1:0] dim_in;

   logic             accept;
   logic             right, bottom;
   logic [POS_W-1:0] off_x, off_y;
   logic [POS_W-1:0] x_in, y_in;

   // Stage 1
   logic             v1_ff;
   logic [POS_W-1:0] x1_ff, y1_ff;
   logic             blend1_ff;
   logic [8:0]       asum1_ff;
   logic [PIX_W-1:0] ovl1_ff;

   // Stage 2
   logic             v2_ff;
   logic [POS_W-1:0] x2_ff, y2_ff;
   logic             ok2_ff, ok2_in;
   logic             blend2_ff;
   logic [CHAN_W-1:0] alpha2_ff, alpha2_in;
   logic [PIX_W-1:0] ovl2_ff;

   // Stage 3 (result register)
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [CHAN_W-1:0] mix_r, mix_g, mix_b;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Configuration
   assign dim_in = (csr_data > DimCap) ? DimCap : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_w_ff <= DIM_W'(1);
         dest_h_ff <= DIM_W'(1);
         ovl_w_ff  <= DIM_W'(1);
         ovl_h_ff  <= DIM_W'(1);
         snap_ff   <= SNAP_TOP_LEFT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEST_WIDTH:     dest_w_ff <= dim_in;
            CSR_DEST_HEIGHT:    dest_h_ff <= dim_in;
            CSR_OVERLAY_WIDTH:  ovl_w_ff  <= dim_in;
            CSR_OVERLAY_HEIGHT: ovl_h_ff  <= dim_in;
            CSR_SNAP_CORNER:    snap_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Snap offset and coordinate shift
   assign right  = (snap_ff == SNAP_TOP_RIGHT) || (snap_ff == SNAP_BOTTOM_RIGHT);
   assign bottom = (snap_ff == SNAP_BOTTOM_LEFT) || (snap_ff == SNAP_BOTTOM_RIGHT);
   assign off_x  = right  ? ({2'b00, dest_w_ff} - {2'b00, ovl_w_ff}) : '0;
   assign off_y  = bottom ? ({2'b00, dest_h_ff} - {2'b00, ovl_h_ff}) : '0;
   assign x_in   = {3'b000, req_data.overlay_col} + off_x;
   assign y_in   = {3'b000, req_data.overlay_row} + off_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff     <= x_in;
      y1_ff     <= y_in;
      blend1_ff <= (req_data.dest_pixel[31:24] != '0) &&
                   (req_data.overlay_pixel[31:24] != FULL_ALPHA);
      asum1_ff  <= {1'b0, req_data.overlay_pixel[31:24]} + {1'b0, req_data.dest_pixel[31:24]};
      ovl1_ff   <= req_data.overlay_pixel;

      x2_ff     <= x1_ff;
      y2_ff     <= y1_ff;
      ok2_ff    <= ok2_in;
      blend2_ff <= blend1_ff;
      alpha2_ff <= alpha2_in;
      ovl2_ff   <= ovl1_ff;

      rsp_ff    <= rsp_in;
   end

   // A nonnegative position fits in the low POS_W-1 bits.
   assign ok2_in = ~x1_ff[POS_W-1] && (x1_ff[POS_W-2:0] < {1'b0, dest_w_ff}) &&
                   ~y1_ff[POS_W-1] && (y1_ff[POS_W-2:0] < {1'b0, dest_h_ff});

   assign alpha2_in = asum1_ff[8] ? FULL_ALPHA : asum1_ff[7:0];

   oabs_mix u_mix_r (
      .clock (clock),
      .src   (req_data.overlay_pixel[23:16]),
      .dst   (req_data.dest_pixel[23:16]),
      .alpha (req_data.overlay_pixel[31:24]),
      .mixed (mix_r)
   );

   oabs_mix u_mix_g (
      .clock (clock),
      .src   (req_data.overlay_pixel[15:8]),
      .dst   (req_data.dest_pixel[15:8]),
      .alpha (req_data.overlay_pixel[31:24]),
      .mixed (mix_g)
   );

   oabs_mix u_mix_b (
      .clock (clock),
      .src   (req_data.overlay_pixel[7:0]),
      .dst   (req_data.dest_pixel[7:0]),
      .alpha (req_data.overlay_pixel[31:24]),
      .mixed (mix_b)
   );

   always_comb begin
      rsp_in.dest_x    = x2_ff[COORD_W-1:0];
      rsp_in.dest_y    = y2_ff[COORD_W-1:0];
      rsp_in.write_ok  = ok2_ff;
      rsp_in.out_pixel = blend2_ff ? {alpha2_ff, mix_r, mix_g, mix_b} : ovl2_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_enter: assert property (@(posedge clock) disable iff (reset) accept |=> v1_ff)
      else $error("accepted beat did not enter stage one");
   a_s1_s2: assert property (@(posedge clock) disable iff (reset) v1_ff |=> v2_ff)
      else $error("beat lost between stage one and two");
   a_s2_out: assert property (@(posedge clock) disable iff (reset) v2_ff |=> rsp_valid)
      else $error("beat lost before the result register");
   a_no_ghost: assert property (@(posedge clock) disable iff (reset) !v2_ff |=> !rsp_valid)
      else $error("result strobe without a beat behind it");
`endif

endmodule

[test/tb_overlay_alpha_blend_snap.sv]
`timescale 1ns / 1ps

module tb_overlay_alpha_blend_snap;
   import oabs_pkg::*;

   localparam int DIM_LIMIT       = 4096;
   localparam int PIPE_DEPTH      = 3;
   localparam int STALL_LIMIT     = 2000;
   localparam int N_PHASES        = 12;
   localparam int BEATS_PER_PHASE = 32;
   localparam int REPORT_MAX      = 10;

   // Register indexes past the end of the map; writes there must be dropped.
   localparam logic [IDX_W-1:0] UNMAPPED_FIRST = CSR_SNAP_CORNER + 1'b1;
   localparam logic [IDX_W-1:0] UNMAPPED_LAST  = '1;

   typedef struct {
      bit               is_csr;
      logic [IDX_W-1:0] idx;
      logic [DIM_W-1:0] val;
      req_type          beat;
      bit               typed;
      rsp_type          want;
   } plan_step_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_data;

   // Shadow of the block's registers, as they stand after reset.
   int         dest_w    = 1;
   int         dest_h    = 1;
   int         ovl_w     = 1;
   int         ovl_h     = 1;
   logic [1:0] corner    = SNAP_TOP_LEFT;

   rsp_type       px_expected[$];
   plan_step_type plan[$];
   bit            csr_open;
   int            bad_beats;
   int            n_sent;
   int            n_seen;
   int            n_blended;
   int            n_offsite;
   int            n_settings;
   int            stall_count;

   overlay_alpha_blend_snap u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int sat_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] mix_chan(input int s, input int d, input int a);
      int v;
      v = (s * a + d * (int'(FULL_ALPHA) - a)) / int'(FULL_ALPHA);
      return v[CHAN_W-1:0];
   endfunction

   // Snap the coordinate to the chosen corner and composite source over destination.
   function automatic rsp_type blend_and_place(input req_type b);
      rsp_type    r;
      int         x;
      int         y;
      int         na;
      logic [7:0] oa;
      logic [7:0] da;
      x = int'(b.overlay_col);
      y = int'(b.overlay_row);
      if (corner == SNAP_TOP_RIGHT || corner == SNAP_BOTTOM_RIGHT) begin
         x = x + dest_w - ovl_w;
      end
      if (corner == SNAP_BOTTOM_LEFT || corner == SNAP_BOTTOM_RIGHT) begin
         y = y + dest_h - ovl_h;
      end
      r.dest_x    = x[COORD_W-1:0];
      r.dest_y    = y[COORD_W-1:0];
      r.write_ok  = (x >= 0) && (x < dest_w) && (y >= 0) && (y < dest_h);
      r.out_pixel = b.overlay_pixel;
      oa = b.overlay_pixel[31:24];
      da = b.dest_pixel[31:24];
      if (da != 0 && oa != FULL_ALPHA) begin
         na = int'(oa) + int'(da);
         if (na > int'(FULL_ALPHA)) begin
            na = int'(FULL_ALPHA);
         end
         r.out_pixel[31:24] = na[7:0];
         for (int c = 0; c < 3; c++) begin
            r.out_pixel[c*8 +: 8] = mix_chan(int'(b.overlay_pixel[c*8 +: 8]),
                                             int'(b.dest_pixel[c*8 +: 8]), int'(oa));
         end
      end
      return r;
   endfunction

   function automatic req_type make_beat(input int col, input int row,
                                         input logic [31:0] ov, input logic [31:0] dp);
      req_type b;
      b.overlay_col   = col[COORD_W-1:0];
      b.overlay_row   = row[COORD_W-1:0];
      b.overlay_pixel = ov;
      b.dest_pixel    = dp;
      return b;
   endfunction

   task automatic plan_beat(input int col, input int row,
                            input logic [31:0] ov, input logic [31:0] dp);
      plan_step_type s;
      s = '{default: '0};
      s.beat = make_beat(col, row, ov, dp);
      plan.push_back(s);
   endtask

   task automatic plan_known(input int col, input int row,
                             input logic [31:0] ov, input logic [31:0] dp,
                             input int x, input int y, input logic [31:0] pix, input bit ok);
      plan_step_type s;
      s = '{default: '0};
      s.beat           = make_beat(col, row, ov, dp);
      s.typed          = 1'b1;
      s.want.dest_x    = x[COORD_W-1:0];
      s.want.dest_y    = y[COORD_W-1:0];
      s.want.out_pixel = pix;
      s.want.write_ok  = ok;
      plan.push_back(s);
   endtask

   task automatic plan_csr(input logic [IDX_W-1:0] idx, input int val);
      plan_step_type s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.idx    = idx;
      s.val    = val[DIM_W-1:0];
      plan.push_back(s);
   endtask

   task automatic send_beat(input req_type b, input rsp_type want);
      start    <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      px_expected.push_back(want);
      n_sent++;
      if (b.dest_pixel[31:24] != 0 && b.overlay_pixel[31:24] != FULL_ALPHA) begin
         n_blended++;
      end
      if (!want.write_ok) begin
         n_offsite++;
      end
   endtask

   task automatic idle_for(input int n);
      start    <= 1'b0;
      req_data <= random_beat();
      repeat (n) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write of a group.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_DEST_WIDTH:     dest_w = sat_dim(val);
         CSR_DEST_HEIGHT:    dest_h = sat_dim(val);
         CSR_OVERLAY_WIDTH:  ovl_w  = sat_dim(val);
         CSR_OVERLAY_HEIGHT: ovl_h  = sat_dim(val);
         CSR_SNAP_CORNER:    corner = val[1:0];
         default: ;
      endcase
   endtask

   // Wait until every pixel in flight has come back, plus a few spare cycles.
   task automatic drain();
      start <= 1'b0;
      while (px_expected.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   function automatic int pick_dim();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64);
   endfunction

   task automatic program_phase(input int ph);
      int         dw;
      int         dh;
      int         ow;
      int         oh;
      int         pick;
      int         wv;
      logic [1:0] cn;
      case (ph)
         0: begin
            dw = DIM_LIMIT; dh = DIM_LIMIT; ow = DIM_LIMIT; oh = DIM_LIMIT;
            cn = SNAP_BOTTOM_RIGHT;
         end
         1: begin
            dw = 1; dh = 1; ow = 1; oh = 1; cn = SNAP_TOP_RIGHT;
         end
         2: begin
            dw = 8191; dh = DIM_LIMIT + 1; ow = 3000; oh = 100; cn = SNAP_BOTTOM_LEFT;
         end
         3: begin
            dw = 10; dh = 10; ow = DIM_LIMIT; oh = DIM_LIMIT; cn = SNAP_BOTTOM_RIGHT;
         end
         4: begin
            dw = 0; dh = 20; ow = 5; oh = 5; cn = SNAP_TOP_LEFT;
         end
         default: begin
            dw = pick_dim(); dh = pick_dim(); ow = pick_dim(); oh = pick_dim();
            pick = $urandom_range(0, 3);
            cn   = pick[1:0];
         end
      endcase
      write_reg(CSR_DEST_WIDTH, dw[DIM_W-1:0]);
      write_reg(CSR_DEST_HEIGHT, dh[DIM_W-1:0]);
      if ($urandom_range(0, 2) == 0) begin
         pick = $urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST);
         wv   = $urandom;
         write_reg(pick[IDX_W-1:0], wv[DIM_W-1:0]);
      end
      write_reg(CSR_OVERLAY_WIDTH, ow[DIM_W-1:0]);
      write_reg(CSR_OVERLAY_HEIGHT, oh[DIM_W-1:0]);
      write_reg(CSR_SNAP_CORNER, {{(DIM_W-2){1'b0}}, cn});
      csr_we <= 1'b0;
      n_settings++;
   endtask

   function automatic req_type random_beat();
      req_type    b;
      int         lim;
      int         pick;
      logic [7:0] oa;
      logic [7:0] da;
      lim  = (ovl_w + 1 > 4095) ? 4095 : ovl_w + 1;
      pick = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, lim);
      b.overlay_col = pick[COORD_W-1:0];
      lim  = (ovl_h + 1 > 4095) ? 4095 : ovl_h + 1;
      pick = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, lim);
      b.overlay_row = pick[COORD_W-1:0];
      case ($urandom_range(0, 5))
         0:       oa = 8'd0;
         1:       oa = FULL_ALPHA;
         2:       oa = FULL_ALPHA - 1'b1;
         default: begin
            pick = $urandom;
            oa   = pick[7:0];
         end
      endcase
      case ($urandom_range(0, 4))
         0:       da = 8'd0;
         1:       da = FULL_ALPHA;
         default: begin
            pick = $urandom;
            da   = pick[7:0];
         end
      endcase
      b.overlay_pixel        = $urandom;
      b.overlay_pixel[31:24] = oa;
      b.dest_pixel           = $urandom;
      b.dest_pixel[31:24]    = da;
      return b;
   endfunction

   // Result checker and stall watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if ((start && !busy) || rsp_valid) begin
         stall_count = 0;
      end else begin
         stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles, %0d pixels outstanding",
                  STALL_LIMIT, px_expected.size());
         $display("Simulation FAILED");
         $finish;
      end else if (!reset && rsp_valid) begin
         n_seen++;
         if (px_expected.size() == 0) begin
            bad_beats++;
            if (bad_beats <= REPORT_MAX) begin
               $display("%0t: unexpected result x=%0d y=%0d pix=%08h ok=%0b", $realtime,
                        rsp_data.dest_x, rsp_data.dest_y, rsp_data.out_pixel,
                        rsp_data.write_ok);
            end
         end else begin
            want = px_expected.pop_front();
            if (rsp_data.dest_x !== want.dest_x || rsp_data.dest_y !== want.dest_y ||
                rsp_data.out_pixel !== want.out_pixel ||
                rsp_data.write_ok !== want.write_ok) begin
               bad_beats++;
               if (bad_beats <= REPORT_MAX) begin
                  $display("%0t: result %0d expected x=%0d y=%0d pix=%08h ok=%0b", $realtime,
                           n_seen, want.dest_x, want.dest_y, want.out_pixel, want.write_ok);
                  $display("%0t: result %0d actual   x=%0d y=%0d pix=%08h ok=%0b", $realtime,
                           n_seen, rsp_data.dest_x, rsp_data.dest_y, rsp_data.out_pixel,
                           rsp_data.write_ok);
               end
            end
         end
      end
   end

   initial begin
      req_type b;
      rsp_type want;
      int      idle_odds;
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_data  = '0;

      // Reset values: 1x1 destination and overlay, top-left snap.
      plan_known(0, 0, 32'hFF123456, 32'h80ABCDEF, 0, 0, 32'hFF123456, 1'b1);
      plan_known(0, 0, 32'h00112233, 32'h00445566, 0, 0, 32'h00112233, 1'b1);
      plan_known(4095, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 4095, 4095, 32'hFFFFFFFF, 1'b0);
      plan_known(1, 0, 32'h00FFFFFF, 32'h7F102030, 1, 0, 32'h7F102030, 1'b0);
      plan_known(0, 0, 32'h00000000, 32'h00000000, 0, 0, 32'h00000000, 1'b1);
      plan_beat(0, 0, 32'h80FF00FF, 32'hFF00FF00);
      plan_beat(0, 0, 32'hFEFFFFFF, 32'h01000000);
      plan_beat(0, 0, 32'h01ABCDEF, 32'h01FEDCBA);
      plan_csr(CSR_DEST_WIDTH, 100);
      plan_csr(CSR_DEST_HEIGHT, 50);
      plan_csr(CSR_OVERLAY_WIDTH, 20);
      plan_csr(CSR_OVERLAY_HEIGHT, 10);
      plan_csr(CSR_SNAP_CORNER, int'(SNAP_TOP_RIGHT));
      plan_beat(0, 0, 32'h40C0FFEE, 32'hC0123456);
      plan_beat(19, 9, 32'hFF0000FF, 32'h80FFFFFF);
      plan_beat(20, 9, 32'h7F7F7F7F, 32'h01010101);
      plan_csr(CSR_SNAP_CORNER, int'(SNAP_BOTTOM_RIGHT));
      plan_beat(19, 9, 32'h20406080, 32'hE0A0C0F0);
      plan_csr(CSR_SNAP_CORNER, int'(SNAP_BOTTOM_LEFT));
      plan_beat(0, 10, 32'h10203040, 32'h50607080);
      // Overlay wider than the destination pushes the column negative.
      plan_csr(CSR_DEST_WIDTH, 10);
      plan_csr(CSR_OVERLAY_WIDTH, 30);
      plan_csr(CSR_SNAP_CORNER, int'(SNAP_TOP_RIGHT));
      plan_beat(0, 0, 32'h99AABBCC, 32'h33445566);
      // Oversized dimensions saturate, so the far corner is inside.
      plan_csr(CSR_DEST_WIDTH, 8191);
      plan_csr(CSR_DEST_HEIGHT, 5000);
      plan_csr(CSR_SNAP_CORNER, int'(SNAP_TOP_LEFT));
      plan_known(4095, 4095, 32'hFF5A5A5A, 32'h12345678, 4095, 4095, 32'hFF5A5A5A, 1'b1);
      // A zero-width destination accepts no pixel at all.
      plan_csr(CSR_DEST_WIDTH, 0);
      plan_known(0, 0, 32'hFF000000, 32'hABCDEF01, 0, 0, 32'hFF000000, 1'b0);
      plan_csr(UNMAPPED_FIRST, 1);
      plan_csr(UNMAPPED_LAST, 8191);
      plan_csr(UNMAPPED_LAST - 1'b1, 0);
      plan_known(0, 0, 32'hFF00FF00, 32'h11111111, 0, 0, 32'hFF00FF00, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!csr_open) begin
               drain();
               csr_open = 1'b1;
               n_settings++;
            end
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            if (csr_open) begin
               csr_we   <= 1'b0;
               csr_open = 1'b0;
            end
            want = plan[i].typed ? plan[i].want : blend_and_place(plan[i].beat);
            send_beat(plan[i].beat, want);
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         program_phase(ph);
         // Some phases run back to back; the final one never idles.
         idle_odds = (ph == N_PHASES - 1 || ph % 3 == 0) ? 0 : 4;
         for (int k = 0; k < BEATS_PER_PHASE; k++) begin
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               idle_for($urandom_range(1, 17));
            end
            b = random_beat();
            send_beat(b, blend_and_place(b));
         end
      end

      drain();
      bad_beats += px_expected.size();
      $display("Sent %0d pixel beats under %0d register settings and checked %0d results.",
               n_sent, n_settings, n_seen);
      $display("Of these %0d were blended and %0d fell outside the destination.",
               n_blended, n_offsite);
      if (bad_beats == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
